### sv/lgs_pkg.sv
package lgs_pkg;

    // Register indexes of the configuration port
    localparam logic CFG_GRID_ROWS = 1'b0;
    localparam logic CFG_GRID_COLS = 1'b1;

    // Command codes
    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic [5:0] SIZE_MIN   = 6'd5;
    localparam logic [5:0] SIZE_RESET = 6'd32;

    // B3/S23
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET_WR,
        ST_DUMP,
        ST_STEP_LOAD,
        ST_STEP
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

    function automatic logic [5:0] clamp_size(logic [5:0] v, logic [5:0] lim);
        logic [5:0] res;
        res = v;
        if (v < SIZE_MIN) begin
            res = SIZE_MIN;
        end else if (v > lim) begin
            res = lim;
        end
        return res;
    endfunction

endpackage

### sv/lgs_row_eval.sv
module lgs_row_eval #(
    parameter int W = 32
) (
    input  logic [W-1:0] i_above,
    input  logic [W-1:0] i_cur,
    input  logic [W-1:0] i_below,
    input  logic [W-1:0] i_mask,
    output logic [W-1:0] o_fresh
);

    // dead padding on both edges: column c sees padded bits c, c+1, c+2
    logic [W+1:0] pad_a;
    logic [W+1:0] pad_c;
    logic [W+1:0] pad_b;

    assign pad_a = {1'b0, i_above, 1'b0};
    assign pad_c = {1'b0, i_cur, 1'b0};
    assign pad_b = {1'b0, i_below, 1'b0};

    for (genvar c = 0; c < W; c++) begin : g_cell
        logic [3:0] nbr;
        assign nbr = 4'(pad_a[c]) + 4'(pad_a[c+1]) + 4'(pad_a[c+2])
                   + 4'(pad_c[c]) + 4'(pad_c[c+2])
                   + 4'(pad_b[c]) + 4'(pad_b[c+1]) + 4'(pad_b[c+2]);
        assign o_fresh[c] = i_mask[c] & ((nbr == lgs_pkg::BIRTH_COUNT)
                          | ((nbr == lgs_pkg::SURVIVE_COUNT) & i_cur[c]));
    end

endmodule

### sv/lgs_grid_mem.sv
module lgs_grid_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    parameter int AW    = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lgs_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]     i_rd_addr,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // row never written reads as all dead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

### sv/life_grid_generation_step_top.sv
// Conway B3/S23 grid engine. A set command (cell alive at row/column) or a step
// command (advance one generation, no wrap, outside cells dead) is taken when
// start is high and busy low; busy then stays high until the whole dump is out.
// Every command is followed by one result per active row, rows 0 up, each shown
// for exactly one cycle under o_strobe, with o_last_row on the final row; the
// receiver must take each result in that cycle. The pace of a command is set by
// the single grid memory read port and the row unit, which evaluates one row
// per cycle. Sizes are clamped to 5..min(MAX,32); config writes are always
// accepted and must only be issued while busy is low.
module life_grid_generation_step_top #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [4:0]  i_cell_row,
    input  logic [4:0]  i_cell_col,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [5:0]  i_cfg_data,
    output logic        o_strobe,
    output logic [4:0]  o_row_index,
    output logic [31:0] o_row_cells,
    output logic        o_last_row,
    output logic        o_coord_error
);

    localparam int ROW_LIM = (MAX_ROWS < 32) ? MAX_ROWS : 32;
    localparam int COL_W   = (MAX_COLS < 32) ? MAX_COLS : 32;
    localparam int AW      = $clog2(ROW_LIM);
    localparam logic [5:0] ROW_LIM6 = 6'(ROW_LIM);
    localparam logic [5:0] COL_LIM6 = 6'(COL_W);

    lgs_pkg::t_state r_state, n_state;

    logic [5:0]       r_grid_rows, r_grid_cols;
    logic             r_cmd, n_cmd;
    logic [5:0]       r_rows, n_rows;
    logic [COL_W-1:0] r_mask, n_mask;
    logic             r_err, n_err;
    logic [AW-1:0]    r_waddr, n_waddr;
    logic [4:0]       r_col, n_col;
    logic [AW-1:0]    r_ptr, n_ptr;
    logic [COL_W-1:0] r_prior, n_prior;
    logic [COL_W-1:0] r_cur, n_cur;

    logic             r_dly_valid, n_dly_valid;
    logic [4:0]       r_dly_idx, n_dly_idx;
    logic             r_dly_last, n_dly_last;

    logic             r_out_valid, n_out_valid;
    logic [4:0]       r_out_idx, n_out_idx;
    logic [COL_W-1:0] r_out_cells, n_out_cells;
    logic             r_out_last, n_out_last;
    logic             r_out_err, n_out_err;

    lgs_pkg::t_mem_ctl mem_ctl;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [COL_W-1:0]  wr_data, rd_data;

    logic [5:0]       cl_rows, cl_cols;
    logic [COL_W-1:0] cols_mask;
    logic [COL_W-1:0] col_bit;
    logic [COL_W-1:0] below;
    logic [COL_W-1:0] fresh;
    logic             in_err;
    logic             ptr_last;
    logic [6:0]       ptr_p1, ptr_p2;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= lgs_pkg::SIZE_RESET;
            r_grid_cols <= lgs_pkg::SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == lgs_pkg::CFG_GRID_ROWS) begin
                r_grid_rows <= i_cfg_data;
            end else begin
                r_grid_cols <= i_cfg_data;
            end
        end
    end

    assign cl_rows = lgs_pkg::clamp_size(r_grid_rows, ROW_LIM6);
    assign cl_cols = lgs_pkg::clamp_size(r_grid_cols, COL_LIM6);

    always_comb begin
        for (int c = 0; c < COL_W; c++) begin
            cols_mask[c] = (6'(c) < cl_cols);
            col_bit[c]   = (5'(c) == r_col);
        end
    end

    assign in_err = (i_command == lgs_pkg::CMD_SET)
                  && !((6'(i_cell_row) < cl_rows) && (6'(i_cell_col) < cl_cols));

    // ---------------- datapath ----------------
    lgs_grid_mem #(
        .DEPTH (ROW_LIM),
        .WIDTH (COL_W),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    assign ptr_p1   = 7'(r_ptr) + 7'd1;
    assign ptr_p2   = 7'(r_ptr) + 7'd2;
    assign ptr_last = (ptr_p1 == 7'(r_rows));
    // rd_data holds row ptr+1 during a step
    assign below    = (ptr_p1 < 7'(r_rows)) ? (rd_data & r_mask) : '0;

    lgs_row_eval #(
        .W (COL_W)
    ) u_eval (
        .i_above (r_prior),
        .i_cur   (r_cur),
        .i_below (below),
        .i_mask  (r_mask),
        .o_fresh (fresh)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_rows      = r_rows;
        n_mask      = r_mask;
        n_err       = r_err;
        n_waddr     = r_waddr;
        n_col       = r_col;
        n_ptr       = r_ptr;
        n_prior     = r_prior;
        n_cur       = r_cur;
        mem_ctl     = '0;
        rd_addr     = '0;
        wr_addr     = '0;
        wr_data     = '0;
        n_dly_valid = 1'b0;
        n_dly_idx   = r_dly_idx;
        n_dly_last  = r_dly_last;
        n_out_valid = 1'b0;
        n_out_idx   = r_out_idx;
        n_out_cells = r_out_cells;
        n_out_last  = r_out_last;
        n_out_err   = r_out_err;

        // dump read data arrives in the cycle after issue, flagged by r_dly_valid
        if (r_dly_valid) begin
            n_out_valid = 1'b1;
            n_out_idx   = r_dly_idx;
            n_out_cells = rd_data & r_mask;
            n_out_last  = r_dly_last;
            n_out_err   = r_err;
        end

        case (r_state)
            lgs_pkg::ST_IDLE: begin
                if (start && !busy) begin
                    n_cmd   = i_command;
                    n_rows  = cl_rows;
                    n_mask  = cols_mask;
                    n_err   = in_err;
                    n_waddr = i_cell_row[AW-1:0];
                    n_col   = i_cell_col;
                    n_ptr   = '0;
                    if (i_command == lgs_pkg::CMD_STEP) begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = '0;
                        n_state       = lgs_pkg::ST_STEP_LOAD;
                    end else if (!in_err) begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = i_cell_row[AW-1:0];
                        n_state       = lgs_pkg::ST_SET_WR;
                    end else begin
                        n_state = lgs_pkg::ST_DUMP;
                    end
                end
            end
            lgs_pkg::ST_SET_WR: begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = r_waddr;
                wr_data       = rd_data | col_bit;
                n_state       = lgs_pkg::ST_DUMP;
            end
            lgs_pkg::ST_DUMP: begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = r_ptr;
                n_dly_valid   = 1'b1;
                n_dly_idx     = 5'(r_ptr);
                n_dly_last    = ptr_last;
                if (ptr_last) begin
                    n_state = lgs_pkg::ST_IDLE;
                end else begin
                    n_ptr = ptr_p1[AW-1:0];
                end
            end
            lgs_pkg::ST_STEP_LOAD: begin
                n_prior       = '0;
                n_cur         = rd_data & r_mask;
                mem_ctl.rd_en = 1'b1;
                rd_addr       = ptr_p1[AW-1:0];
                n_state       = lgs_pkg::ST_STEP;
            end
            lgs_pkg::ST_STEP: begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = r_ptr;
                wr_data       = fresh;
                if (ptr_p2 < 7'(r_rows)) begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = ptr_p2[AW-1:0];
                end
                n_prior     = r_cur;
                n_cur       = below;
                n_out_valid = 1'b1;
                n_out_idx   = 5'(r_ptr);
                n_out_cells = fresh;
                n_out_last  = ptr_last;
                n_out_err   = 1'b0;
                if (ptr_last) begin
                    n_state = lgs_pkg::ST_IDLE;
                end else begin
                    n_ptr = ptr_p1[AW-1:0];
                end
            end
            default: begin
                n_state = lgs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lgs_pkg::ST_IDLE;
            r_dly_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dly_valid <= n_dly_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_rows      <= n_rows;
        r_mask      <= n_mask;
        r_err       <= n_err;
        r_waddr     <= n_waddr;
        r_col       <= n_col;
        r_ptr       <= n_ptr;
        r_prior     <= n_prior;
        r_cur       <= n_cur;
        r_dly_idx   <= n_dly_idx;
        r_dly_last  <= n_dly_last;
        r_out_idx   <= n_out_idx;
        r_out_cells <= n_out_cells;
        r_out_last  <= n_out_last;
        r_out_err   <= n_out_err;
    end

    assign busy          = (r_state != lgs_pkg::ST_IDLE) || r_dly_valid || r_out_valid;
    assign o_strobe      = r_out_valid;
    assign o_row_index   = r_out_idx;
    assign o_row_cells   = 32'(r_out_cells);
    assign o_last_row    = r_out_last;
    assign o_coord_error = r_out_err;

    // ---------------- assertions ----------------
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while not busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepting an item");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_row) |-> (o_row_index == 5'(r_rows - 6'd1)))
        else $error("last row flag on wrong row");

    a_row_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_row) |=>
            (o_strobe && (o_row_index == 5'($past(o_row_index) + 5'd1))))
        else $error("dump rows not consecutive");

    a_err_set_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_coord_error) |-> (r_cmd == lgs_pkg::CMD_SET))
        else $error("coordinate error on a step dump");

endmodule
